### rtl/kwm_pkg.sv
`default_nettype none

package kwm_pkg;

   localparam int WAYS       = 8;
   localparam int VALUE_BITS = 32;
   localparam int SRC_BITS   = 3;
   localparam int COUNT_BITS = 4;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(WAYS);

   typedef struct packed {
      logic [SRC_BITS-1:0]          source;
      logic signed [VALUE_BITS-1:0] value;
      logic                         source_last;
      logic                         source_empty;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] merged_value;
      logic [SRC_BITS-1:0]          from_source;
      logic                         merge_done;
      logic                         rejected;
   } rsp_word_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_EMIT
   } state_type;

endpackage

`default_nettype wire

### rtl/k_way_sorted_merge.sv
`default_nettype none

// Merges up to eight ascending streams into one ascending stream. Each req word
// brings the next head of one source (or marks the source empty); once every
// active source holds a head or is exhausted the smallest head is sent on rsp,
// ties going to the lowest source, and the last word of the whole merge carries
// merge_done. A word that clashes with a held or exhausted source, or names a
// source beyond the active count, is answered by one rejected word in the cycle
// after it is taken, and the block stays idle for the next word. Otherwise the
// word is stored and a single signed comparator walks the held heads, one source
// per cycle, over the n active sources; the emit step then returns to idle if a
// source still lacks a head, clears the merge if every source is empty, or issues
// the smallest head, waiting on rsp_ready, and starts a new pass until the merge
// is done, so one word can release a run of results.
// req_ready stays low while a pass runs. A csr write sets the count and clears
// the merge state.
module k_way_sorted_merge (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire kwm_pkg::req_word_type  req,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output kwm_pkg::rsp_word_type       rsp,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire [kwm_pkg::COUNT_BITS-1:0] csr_data
);

   localparam int W  = kwm_pkg::WAYS;
   localparam int CB = kwm_pkg::COUNT_BITS;
   localparam int SB = kwm_pkg::SRC_BITS;
   localparam int VB = kwm_pkg::VALUE_BITS;

   kwm_pkg::state_type state_ff, state_in;
   logic [CB-1:0]        count_ff, count_in;
   logic [SB-1:0]        idx_ff, idx_in;
   logic [W-1:0]         held_ff, held_in;
   logic [W-1:0]         exh_ff, exh_in;
   logic [W-1:0]         lastp_ff, lastp_in;
   logic signed [VB-1:0] head_ff [W];
   logic                 best_any_ff, best_any_in;
   logic [SB-1:0]        best_idx_ff, best_idx_in;
   logic signed [VB-1:0] best_val_ff, best_val_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   kwm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [W-1:0] active_mask;
   logic [W-1:0] exh_after;
   logic         req_fire, csr_fire, out_free, reject, all_ready, done, emit_fire;
   logic         head_write;
   logic [CB-1:0] csr_count;

   always_comb begin
      for (int i = 0; i < W; i++) begin
         active_mask[i] = CB'(i) < count_ff;
      end
   end

   // active count clamped to one .. ways
   always_comb begin
      priority if (csr_data == '0) begin
         csr_count = CB'(1);
      end else if (csr_data > kwm_pkg::COUNT_RESET) begin
         csr_count = kwm_pkg::COUNT_RESET;
      end else begin
         csr_count = csr_data;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == kwm_pkg::STATE_IDLE) && out_free;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign reject    = ({1'b0, req.source} >= count_ff) || held_ff[req.source]
                      || exh_ff[req.source];
   assign all_ready = &((held_ff | exh_ff) | ~active_mask);
   assign exh_after = exh_ff | (lastp_ff & (W'(1) << best_idx_ff));
   assign done      = &(exh_after | ~active_mask);
   assign emit_fire = (state_ff == kwm_pkg::STATE_EMIT) && all_ready && best_any_ff
                      && out_free;
   assign head_write = req_fire && !reject && !req.source_empty;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      held_in      = held_ff;
      exh_in       = exh_ff;
      lastp_in     = lastp_ff;
      best_any_in  = best_any_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;

      unique case (state_ff)
         kwm_pkg::STATE_IDLE: begin
            if (req_fire) begin
               if (reject) begin
                  rsp_valid_in             = 1'b1;
                  rsp_word_in.merged_value = '0;
                  rsp_word_in.from_source  = req.source;
                  rsp_word_in.merge_done   = 1'b0;
                  rsp_word_in.rejected     = 1'b1;
               end else begin
                  if (req.source_empty) begin
                     exh_in[req.source] = 1'b1;
                  end else begin
                     held_in[req.source]  = 1'b1;
                     lastp_in[req.source] = req.source_last;
                  end
                  idx_in      = '0;
                  best_any_in = 1'b0;
                  state_in    = kwm_pkg::STATE_SCAN;
               end
            end
         end
         kwm_pkg::STATE_SCAN: begin
            // one head per cycle through the shared comparator
            if (held_ff[idx_ff] && (!best_any_ff || (head_ff[idx_ff] < best_val_ff))) begin
               best_any_in = 1'b1;
               best_idx_in = idx_ff;
               best_val_in = head_ff[idx_ff];
            end
            if ({1'b0, idx_ff} == count_ff - CB'(1)) begin
               state_in = kwm_pkg::STATE_EMIT;
            end else begin
               idx_in = idx_ff + SB'(1);
            end
         end
         kwm_pkg::STATE_EMIT: begin
            priority if (!all_ready) begin
               state_in = kwm_pkg::STATE_IDLE;
            end else if (!best_any_ff) begin
               // every active source empty: clear without a word
               held_in  = '0;
               exh_in   = '0;
               lastp_in = '0;
               state_in = kwm_pkg::STATE_IDLE;
            end else if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.merged_value = best_val_ff;
               rsp_word_in.from_source  = best_idx_ff;
               rsp_word_in.merge_done   = done;
               rsp_word_in.rejected     = 1'b0;
               if (done) begin
                  held_in  = '0;
                  exh_in   = '0;
                  lastp_in = '0;
                  state_in = kwm_pkg::STATE_IDLE;
               end else begin
                  held_in[best_idx_ff]  = 1'b0;
                  lastp_in[best_idx_ff] = 1'b0;
                  exh_in                = exh_after;
                  idx_in                = '0;
                  best_any_in           = 1'b0;
                  state_in              = kwm_pkg::STATE_SCAN;
               end
            end
         end
         default: begin
            state_in = kwm_pkg::STATE_IDLE;
         end
      endcase

      if (csr_fire) begin
         count_in = csr_count;
         held_in  = '0;
         exh_in   = '0;
         lastp_in = '0;
         state_in = kwm_pkg::STATE_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kwm_pkg::STATE_IDLE;
         count_ff     <= kwm_pkg::COUNT_RESET;
         held_ff      <= '0;
         exh_ff       <= '0;
         lastp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         best_any_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         exh_ff       <= exh_in;
         lastp_ff     <= lastp_in;
         rsp_valid_ff <= rsp_valid_in;
         best_any_ff  <= best_any_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      rsp_word_ff <= rsp_word_in;
      if (head_write) begin
         head_ff[req.source] <= req.value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_word_ff;

   a_reject_answered: assert property (@(posedge clock) disable iff (reset)
      req_fire && reject && !csr_fire |=> rsp_valid && rsp.rejected)
      else $error("rejected word not answered");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != kwm_pkg::STATE_IDLE |-> !req_ready)
      else $error("req taken during a pass");

   a_emit_from_held: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> held_ff[best_idx_ff] && active_mask[best_idx_ff])
      else $error("emitted source holds no head");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      emit_fire && done && !csr_fire |=> held_ff == '0 && exh_ff == '0)
      else $error("merge state not cleared after final word");

endmodule

`default_nettype wire

### sim/k_way_sorted_merge_tb.sv
module k_way_sorted_merge_tb;

   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     SETTLE_CYCLES  = 90;
   localparam int     RANDOM_ITEMS   = 300;
   localparam longint VALUE_MIN      = -(longint'(1) << 31);
   localparam longint VALUE_MAX      = (longint'(1) << 31) - 1;

   typedef enum logic {ROW_WORD, ROW_COUNT} row_kind_type;

   typedef struct {
      row_kind_type                   kind;
      logic [kwm_pkg::COUNT_BITS-1:0] count;
      kwm_pkg::req_word_type          word;
      bit                             typed;
      kwm_pkg::rsp_word_type          want;
   } script_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   kwm_pkg::req_word_type          req;
   logic                           rsp_valid;
   logic                           rsp_ready;
   kwm_pkg::rsp_word_type          rsp;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [kwm_pkg::COUNT_BITS-1:0] csr_data;

   // merge state as the block should hold it
   logic [kwm_pkg::COUNT_BITS-1:0]        count_setting;
   logic signed [kwm_pkg::VALUE_BITS-1:0] slot_value [kwm_pkg::WAYS];
   bit                                    slot_full  [kwm_pkg::WAYS];
   bit                                    slot_dry   [kwm_pkg::WAYS];
   bit                                    slot_final [kwm_pkg::WAYS];
   bit                                    merge_cleared;

   kwm_pkg::rsp_word_type          step_results[$];
   kwm_pkg::rsp_word_type          merged_expect[$];
   logic [kwm_pkg::VALUE_BITS-1:0] stream_q[kwm_pkg::WAYS][$];
   script_row_type                 script_rows[$];
   int                             mismatches;
   bit                             gaps_on;

   k_way_sorted_merge u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int ways_in_use();
      if (count_setting == '0) return 1;
      if (int'(count_setting) > kwm_pkg::WAYS) return kwm_pkg::WAYS;
      return int'(count_setting);
   endfunction

   function automatic void clear_slots();
      for (int s = 0; s < kwm_pkg::WAYS; s++) begin
         slot_value[s] = '0;
         slot_full[s]  = 1'b0;
         slot_dry[s]   = 1'b0;
         slot_final[s] = 1'b0;
      end
   endfunction

   function automatic kwm_pkg::req_word_type req_of(int src,
                                                    logic [kwm_pkg::VALUE_BITS-1:0] val,
                                                    int last, int empty);
      kwm_pkg::req_word_type w;
      w.source       = src[kwm_pkg::SRC_BITS-1:0];
      w.value        = val;
      w.source_last  = last[0];
      w.source_empty = empty[0];
      return w;
   endfunction

   function automatic kwm_pkg::rsp_word_type rsp_of(logic [kwm_pkg::VALUE_BITS-1:0] val,
                                                    int src, int done, int rej);
      kwm_pkg::rsp_word_type r;
      r.merged_value = val;
      r.from_source  = src[kwm_pkg::SRC_BITS-1:0];
      r.merge_done   = done[0];
      r.rejected     = rej[0];
      return r;
   endfunction

   // takes one accepted word, leaves the words it releases in step_results
   function automatic void advance_merge(kwm_pkg::req_word_type w);
      int  n;
      int  best;
      bit  all_in;
      bit  found;
      bit  done;
      step_results.delete();
      merge_cleared = 1'b0;
      n = ways_in_use();
      if (int'(w.source) >= n || slot_full[w.source] || slot_dry[w.source]) begin
         step_results.push_back(rsp_of('0, int'(w.source), 0, 1));
         return;
      end
      if (w.source_empty) begin
         slot_dry[w.source] = 1'b1;
      end else begin
         slot_value[w.source] = w.value;
         slot_full[w.source]  = 1'b1;
         slot_final[w.source] = w.source_last;
      end
      for (int k = 0; k < kwm_pkg::WAYS; k++) begin
         all_in = 1'b1;
         found  = 1'b0;
         best   = 0;
         for (int i = 0; i < n; i++) begin
            if (!slot_full[i] && !slot_dry[i]) all_in = 1'b0;
            // strict compare keeps ties on the lowest source
            if (slot_full[i] && (!found || slot_value[i] < slot_value[best])) begin
               best  = i;
               found = 1'b1;
            end
         end
         if (!all_in) break;
         if (!found) begin
            clear_slots();
            merge_cleared = 1'b1;
            break;
         end
         slot_full[best] = 1'b0;
         if (slot_final[best]) slot_dry[best] = 1'b1;
         slot_final[best] = 1'b0;
         done = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (!slot_dry[i]) done = 1'b0;
         end
         step_results.push_back(rsp_of(slot_value[best], best, int'(done), 0));
         if (done) begin
            clear_slots();
            merge_cleared = 1'b1;
            break;
         end
      end
   endfunction

   // fresh ascending streams for the active sources, some with many ties
   function automatic void fill_streams();
      longint v;
      int     len;
      int     mode;
      for (int s = 0; s < kwm_pkg::WAYS; s++) begin
         stream_q[s].delete();
         if (s >= ways_in_use()) continue;
         len  = $urandom_range(0, 4);
         mode = $urandom_range(0, 2);
         case (mode)
            0: begin
               v = longint'($signed($urandom));
            end
            1: begin
               v = longint'($urandom_range(0, 4)) - 2;
            end
            default: begin
               v = VALUE_MIN + longint'($urandom_range(0, 2));
            end
         endcase
         for (int k = 0; k < len; k++) begin
            stream_q[s].push_back(v[kwm_pkg::VALUE_BITS-1:0]);
            if (mode == 1) v += longint'($urandom_range(0, 1));
            else v += longint'($urandom_range(0, 32'h7fffffff));
            if (v > VALUE_MAX) v = VALUE_MAX;
         end
      end
   endfunction

   function automatic void add_row(row_kind_type kind, logic [kwm_pkg::COUNT_BITS-1:0] n,
                                   kwm_pkg::req_word_type word, bit typed,
                                   kwm_pkg::rsp_word_type want);
      script_row_type row;
      row.kind  = kind;
      row.count = n;
      row.word  = word;
      row.typed = typed;
      row.want  = want;
      script_rows.push_back(row);
   endfunction

   task automatic flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic drive_word(kwm_pkg::req_word_type word);
      while (gaps_on && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= word;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_count(logic [kwm_pkg::COUNT_BITS-1:0] n);
      req_valid <= 1'b0;
      while (merged_expect.size() != 0) @(posedge clock);
      // a word that releases nothing may still be in its comparator pass
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_setting = n;
      clear_slots();
      fill_streams();
   endtask

   // result side: check each word taken, stall at random
   always @(posedge clock) begin
      kwm_pkg::rsp_word_type want;
      string                 note;
      if (!reset && rsp_valid && rsp_ready) begin
         if (merged_expect.size() == 0) begin
            flag_mismatch($sformatf("rsp word %h with nothing expected", rsp));
         end else begin
            want = merged_expect.pop_front();
            note = "";
            if (rsp.merged_value !== want.merged_value)
               note = {note, $sformatf(" merged_value %0d/%0d", rsp.merged_value,
                                       want.merged_value)};
            if (rsp.from_source !== want.from_source)
               note = {note, $sformatf(" from_source %0d/%0d", rsp.from_source,
                                       want.from_source)};
            if (rsp.merge_done !== want.merge_done)
               note = {note, $sformatf(" merge_done %b/%b", rsp.merge_done, want.merge_done)};
            if (rsp.rejected !== want.rejected)
               note = {note, $sformatf(" rejected %b/%b", rsp.rejected, want.rejected)};
            if (note != "") flag_mismatch({"rsp word got/wanted:", note});
         end
      end
      rsp_ready <= !reset && !(gaps_on && $urandom_range(99) < 8);
   end

   initial begin
      int                    quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL k_way_sorted_merge");
      $finish;
   end

   initial begin
      script_row_type                 row;
      int                             phase;
      int                             phase_items;
      int                             phase_limit;
      int                             done_items;
      int                             pick;
      int                             needy[$];
      logic [kwm_pkg::COUNT_BITS-1:0] next_count;
      logic [kwm_pkg::VALUE_BITS-1:0] v;
      kwm_pkg::req_word_type          word;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req        = '0;
      rsp_ready  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      mismatches = 0;
      gaps_on    = 1'b1;
      count_setting = kwm_pkg::COUNT_RESET;
      clear_slots();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single stream: each word ends the merge at once
      add_row(ROW_COUNT, 4'd1, '0, 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(0, 32'h7fffffff, 1, 0), 1'b1,
              rsp_of(32'h7fffffff, 0, 1, 0));
      add_row(ROW_WORD, '0, req_of(0, 32'h80000000, 1, 0), 1'b1,
              rsp_of(32'h80000000, 0, 1, 0));
      add_row(ROW_WORD, '0, req_of(1, 3, 0, 0), 1'b1, rsp_of('0, 1, 0, 1));
      // every stream empty: clears with no word out
      add_row(ROW_WORD, '0, req_of(0, 0, 0, 1), 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(0, -7, 0, 0), 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(0, 9, 1, 0), 1'b1, rsp_of(32'd9, 0, 1, 0));
      // zero acts as one
      add_row(ROW_COUNT, 4'd0, '0, 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(0, -1, 1, 0), 1'b1, rsp_of(32'hffffffff, 0, 1, 0));
      add_row(ROW_WORD, '0, req_of(7, 32'h5a5a5a5a, 1, 1), 1'b1, rsp_of('0, 7, 0, 1));
      // above the way count acts as all eight
      add_row(ROW_COUNT, 4'd15, '0, 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(3, 10, 0, 0), 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(3, 11, 0, 0), 1'b1, rsp_of('0, 3, 0, 1));
      add_row(ROW_WORD, '0, req_of(2, 0, 0, 1), 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(2, 1, 1, 0), 1'b1, rsp_of('0, 2, 0, 1));
      add_row(ROW_WORD, '0, req_of(0, 32'h80000000, 0, 0), 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(1, 32'h7fffffff, 1, 0), 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(4, 10, 1, 0), 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(5, 10, 1, 0), 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(6, 32'hffffffff, 1, 1), 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(7, -5, 1, 0), 1'b0, '0);
      // four-way tie at ten, then the rest drains in one run
      add_row(ROW_WORD, '0, req_of(0, 10, 1, 0), 1'b0, '0);
      add_row(ROW_WORD, '0, req_of(3, 12, 1, 0), 1'b0, '0);

      for (int r = 0; r < script_rows.size(); r++) begin
         row = script_rows[r];
         if (row.kind == ROW_COUNT) begin
            write_count(row.count);
         end else begin
            drive_word(row.word);
            advance_merge(row.word);
            if (row.typed) merged_expect.push_back(row.want);
            else foreach (step_results[i]) merged_expect.push_back(step_results[i]);
         end
      end

      phase      = 0;
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         case (phase)
            0: next_count = 4'd8;
            1: next_count = 4'd1;
            2: next_count = 4'd15;
            3: next_count = 4'd0;
            4: next_count = 4'd2;
            default: next_count = 4'($urandom_range(0, 15));
         endcase
         write_count(next_count);
         phase_items = 0;
         phase_limit = $urandom_range(20, 50);
         while (phase_items < phase_limit && done_items < RANDOM_ITEMS) begin
            gaps_on = !(done_items >= 100 && done_items < 180);
            needy.delete();
            for (int s = 0; s < ways_in_use(); s++) begin
               if (!slot_full[s] && !slot_dry[s]) needy.push_back(s);
            end
            if (needy.size() == 0 || $urandom_range(99) < 12) begin
               word = req_of(int'($urandom_range(0, 7)), $urandom,
                             int'($urandom_range(0, 1)), int'($urandom_range(0, 1)));
            end else begin
               pick = needy[$urandom_range(0, needy.size() - 1)];
               if (stream_q[pick].size() == 0) begin
                  word = req_of(pick, $urandom, int'($urandom_range(0, 1)), 1);
               end else begin
                  v    = stream_q[pick].pop_front();
                  word = req_of(pick, v, int'(stream_q[pick].size() == 0), 0);
               end
            end
            drive_word(word);
            advance_merge(word);
            foreach (step_results[i]) merged_expect.push_back(step_results[i]);
            done_items++;
            phase_items++;
            if (merge_cleared) fill_streams();
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (merged_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS k_way_sorted_merge");
      else
         $display("FAIL k_way_sorted_merge");
      $finish;
   end

endmodule
